/* src/a85_pkg.sv */
// ----------------------------------------------------------------------------
// a85_pkg
// Shared types and character constants for the ascii85 stream decoder.
// ----------------------------------------------------------------------------
package a85_pkg;

    // character codes
    localparam logic [7:0] FIRST_DIGIT = 8'h21;   // '!'
    localparam logic [7:0] LAST_DIGIT  = 8'h75;   // 'u'
    localparam logic [7:0] ZERO_GROUP  = 8'h7A;   // 'z'
    localparam logic [7:0] TILDE       = 8'h7E;   // '~'
    localparam logic [7:0] CLOSE       = 8'h3E;   // '>'

    localparam int BASE  = 85;
    // a group of up to four digits stays below 85^4
    localparam int ACC_W = 26;

    typedef enum logic [2:0] {
        K_DATA     = 3'd0,
        K_END      = 3'd1,
        K_ILLEGAL  = 3'd2,
        K_LONE     = 3'd3,
        K_OVERFLOW = 3'd4
    } t_kind;

    // what follows the optional four-byte group of a command
    typedef enum logic [1:0] {
        TAIL_NONE     = 2'd0,
        TAIL_ILLEGAL  = 2'd1,
        TAIL_OVERFLOW = 2'd2,
        TAIL_FINISH   = 2'd3
    } t_tail;

    typedef struct packed {
        logic [7:0] in_char;
        logic       is_final;
    } t_in;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
        logic       run_last;
    } t_out;

    // one command from the front to the back
    typedef struct packed {
        logic             grp;    // four bytes of word first
        logic [31:0]      word;
        t_tail            tail;
        logic [2:0]       pos;    // digits of the group left at finish
        logic [ACC_W-1:0] acc;    // value of those digits
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage

/* src/a85_front.sv */
// ----------------------------------------------------------------------------
// a85_front
// Character classifier: keeps the group state and turns each character into
// at most one command for the back end.
// ----------------------------------------------------------------------------
module a85_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  a85_pkg::t_in   i_item,
    output logic           o_push,
    output a85_pkg::t_cmd  o_cmd
);
    import a85_pkg::*;

    logic [ACC_W-1:0] r_acc, n_acc;
    logic [2:0]       r_pos, n_pos;
    logic             r_tilde, n_tilde;
    logic             r_disc, n_disc;

    logic [7:0]  w_c;
    logic        w_fin;
    logic        w_stop;
    logic        w_space;
    logic [7:0]  w_digit;
    logic [32:0] w_sum;
    t_cmd        w_cmd;

    assign w_c     = i_item.in_char;
    assign w_fin   = i_item.is_final;
    // nul, tab, lf, ff, cr and space
    assign w_space = (w_c == 8'd0) || (w_c == 8'd9) || (w_c == 8'd10) ||
                     (w_c == 8'd12) || (w_c == 8'd13) || (w_c == 8'd32);
    assign w_digit = w_c - FIRST_DIGIT;
    assign w_sum   = 33'(r_acc) * 33'(BASE) + 33'(w_digit);

    always_comb begin
        n_acc   = r_acc;
        n_pos   = r_pos;
        n_tilde = r_tilde;
        n_disc  = r_disc;
        w_stop  = 1'b0;
        w_cmd   = '0;
        w_cmd.tail = TAIL_NONE;
        if (i_take) begin
            if (r_disc) begin
                if (w_fin) begin
                    n_acc  = '0;
                    n_pos  = '0;
                    n_disc = 1'b0;
                end
            end else begin
                if (r_tilde) begin
                    n_tilde = 1'b0;
                    w_stop  = 1'b1;
                    if (w_c == CLOSE) begin
                        w_cmd.tail = TAIL_FINISH;
                        w_cmd.pos  = r_pos;
                        w_cmd.acc  = r_acc;
                    end else begin
                        w_cmd.tail = TAIL_ILLEGAL;
                    end
                end else if (w_space) begin
                    n_acc = r_acc;
                end else if ((w_c == ZERO_GROUP) && (r_pos == 3'd0)) begin
                    w_cmd.grp = 1'b1;
                end else if ((w_c == TILDE) && !w_fin) begin
                    n_tilde = 1'b1;
                end else if ((w_c >= FIRST_DIGIT) && (w_c <= LAST_DIGIT)) begin
                    if (r_pos == 3'd4) begin
                        if (w_sum[32]) begin
                            w_cmd.tail = TAIL_OVERFLOW;
                            w_stop     = 1'b1;
                        end else begin
                            w_cmd.grp  = 1'b1;
                            w_cmd.word = w_sum[31:0];
                        end
                        n_acc = '0;
                        n_pos = '0;
                    end else begin
                        n_acc = w_sum[ACC_W-1:0];
                        n_pos = r_pos + 3'd1;
                    end
                end else begin
                    w_cmd.tail = TAIL_ILLEGAL;
                    w_stop     = 1'b1;
                end

                if (w_fin) begin
                    if (!w_stop) begin
                        w_cmd.tail = TAIL_FINISH;
                        w_cmd.pos  = n_pos;
                        w_cmd.acc  = n_acc;
                    end
                    n_acc   = '0;
                    n_pos   = '0;
                    n_tilde = 1'b0;
                    n_disc  = 1'b0;
                end else if (w_stop) begin
                    n_acc   = '0;
                    n_pos   = '0;
                    n_tilde = 1'b0;
                    n_disc  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_pos   <= '0;
            r_tilde <= 1'b0;
            r_disc  <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_pos   <= n_pos;
            r_tilde <= n_tilde;
            r_disc  <= n_disc;
        end
    end

    assign o_push = i_take && !r_disc && (w_cmd.grp || (w_cmd.tail != TAIL_NONE));
    assign o_cmd  = w_cmd;

endmodule

/* src/a85_fifo.sv */
// ----------------------------------------------------------------------------
// a85_fifo
// Short command queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module a85_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  a85_pkg::t_cmd   i_cmd,
    input  logic            i_pop,
    output a85_pkg::t_cmd   o_cmd,
    output a85_pkg::t_qstat o_stat
);
    import a85_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
        logic [AW-1:0] q;
        q = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
        return q;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= nxt(r_wr);
            end
            if (i_pop) begin
                r_rd <= nxt(r_rd);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_cmd        = r_mem[r_rd];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == CW'(DEPTH));

endmodule

/* src/a85_back.sv */
// ----------------------------------------------------------------------------
// a85_back
// Result sequencer: plays out each command as data bytes and status results
// into a registered output stage.
// ----------------------------------------------------------------------------
module a85_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  a85_pkg::t_qstat i_qstat,
    input  a85_pkg::t_cmd   i_cmd,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output a85_pkg::t_out   o_out_data
);
    import a85_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_GRP  = 3'b010,
        S_TAIL = 3'b100
    } t_state;

    t_state      r_state, n_state;
    t_cmd        r_cmd, n_cmd;
    logic [1:0]  r_idx, n_idx;
    logic [32:0] r_pad;
    logic        r_pad_ok;
    logic        r_out_valid;
    t_out        r_out;

    logic        w_free, w_emit, w_done, w_pop;
    t_out        w_res;
    logic [26:0] w_acc1;
    logic [46:0] w_prod;

    // 85^(5-pos): padding with 'u' equals (acc+1)*85^k - 1
    function automatic logic [19:0] pad_mult(input logic [2:0] pos);
        logic [19:0] m;
        case (pos)
            3'd2:    m = 20'd614125;
            3'd3:    m = 20'd7225;
            3'd4:    m = 20'd85;
            default: m = 20'd1;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [1:0] i);
        logic [7:0] b;
        case (i)
            2'd0:    b = w[31:24];
            2'd1:    b = w[23:16];
            2'd2:    b = w[15:8];
            default: b = w[7:0];
        endcase
        return b;
    endfunction

    assign w_acc1 = 27'(r_cmd.acc) + 27'd1;
    assign w_prod = 47'(w_acc1) * 47'(pad_mult(r_cmd.pos));
    assign w_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_idx   = r_idx;
        w_emit  = 1'b0;
        w_done  = 1'b0;
        w_pop   = 1'b0;
        w_res   = '0;
        w_res.kind = K_DATA;
        case (r_state)
            S_IDLE: begin
                w_done = 1'b1;
            end
            S_GRP: begin
                if (w_free) begin
                    w_emit          = 1'b1;
                    w_res.data_byte = byte_of(r_cmd.word, r_idx);
                    if (r_idx == 2'd3) begin
                        n_idx = '0;
                        if (r_cmd.tail == TAIL_NONE) begin
                            w_res.run_last = 1'b1;
                            w_done         = 1'b1;
                        end else begin
                            n_state = S_TAIL;
                        end
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end
            end
            S_TAIL: begin
                if (w_free) begin
                    case (r_cmd.tail)
                        TAIL_ILLEGAL: begin
                            w_emit = 1'b1;
                            w_done = 1'b1;
                            w_res.kind     = K_ILLEGAL;
                            w_res.run_last = 1'b1;
                        end
                        TAIL_OVERFLOW: begin
                            w_emit = 1'b1;
                            w_done = 1'b1;
                            w_res.kind     = K_OVERFLOW;
                            w_res.run_last = 1'b1;
                        end
                        TAIL_FINISH: begin
                            if (r_cmd.pos == 3'd0) begin
                                w_emit = 1'b1;
                                w_done = 1'b1;
                                w_res.kind     = K_END;
                                w_res.run_last = 1'b1;
                            end else if (r_cmd.pos == 3'd1) begin
                                w_emit = 1'b1;
                                w_done = 1'b1;
                                w_res.kind     = K_LONE;
                                w_res.run_last = 1'b1;
                            end else if (r_pad_ok) begin
                                w_emit = 1'b1;
                                if (r_pad[32]) begin
                                    w_done = 1'b1;
                                    w_res.kind     = K_OVERFLOW;
                                    w_res.run_last = 1'b1;
                                end else if ((3'(r_idx) + 3'd1) < r_cmd.pos) begin
                                    w_res.data_byte = byte_of(r_pad[31:0], r_idx);
                                    n_idx = r_idx + 2'd1;
                                end else begin
                                    w_done = 1'b1;
                                    w_res.kind     = K_END;
                                    w_res.run_last = 1'b1;
                                end
                            end
                        end
                        default: begin
                            w_done = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_done) begin
            if (!i_qstat.empty) begin
                w_pop   = 1'b1;
                n_cmd   = i_cmd;
                n_idx   = '0;
                n_state = i_cmd.grp ? S_GRP : S_TAIL;
            end else begin
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_pad_ok    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_pad_ok <= !w_pop;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_pad <= w_prod[32:0] - 33'd1;
        if (w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_pop       = w_pop;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* src/ascii85_stream_decoder.sv */
// ----------------------------------------------------------------------------
// ascii85_stream_decoder
// Character-serial ascii85 decoder with a decoupled classifier and result
// sequencer.
// ----------------------------------------------------------------------------
// One character is accepted per clock while the command queue has room. The
// front end classifies each character in the cycle it is accepted, updates
// the running group value with one multiply-add by 85, and queues at most one
// command. The back end plays commands out at one result per clock, while the
// output is ready, through a registered output stage; a full group or 'z'
// gives four data bytes and the queue (QUEUE_DEPTH entries) absorbs those
// bursts; input stalls only when the queue is full. A finish of a partial
// group of two or more digits waits for the registered padding multiply when
// it is the first thing of its command. A character's earliest result passes
// through the queue, command register and output register. Whitespace, pending
// '~' and digits that do not complete a group produce nothing.
module ascii85_stream_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  a85_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output a85_pkg::t_out o_out_data
);
    import a85_pkg::*;

    logic   w_take;     // input request accepted this cycle
    logic   w_push;     // classifier produced a command
    logic   w_pop;      // sequencer took the head command
    t_cmd   w_cmd_in;
    t_cmd   w_cmd_out;
    t_qstat w_qstat;

    // accept whenever the queue can take a command
    assign o_in_ready = !w_qstat.full;
    assign w_take     = i_in_valid && o_in_ready;

    // classifier and group state
    a85_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_item  (i_in_data),
        .o_push  (w_push),
        .o_cmd   (w_cmd_in)
    );

    // command queue
    a85_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out),
        .o_stat  (w_qstat)
    );

    // result sequencer with output register
    a85_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qstat     (w_qstat),
        .i_cmd       (w_cmd_out),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef ASSERT_OFF
    // status results close their item and carry no byte
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.kind != K_DATA)) |->
        (o_out_data.run_last && (o_out_data.data_byte == 8'd0)))
        else $error("status result without run_last or with nonzero byte");

    // no command is pushed into a full queue
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("command queue overrun");

    // no pop from an empty queue
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("command queue underrun");

    // output is idle right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");
`endif

endmodule
